// File: rtl/ctt_pkg.sv
package ctt_pkg;

  localparam int unsigned EntriesDefault = 64;

  typedef enum logic [1:0] {
    OP_TRACK  = 2'd0,
    OP_INSERT = 2'd1,
    OP_TICK   = 2'd2,
    OP_SWEEP  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    PC_NONE = 2'd0,
    PC_ICMP = 2'd1,
    PC_TCP  = 2'd2,
    PC_UDP  = 2'd3
  } proto_e;

  typedef enum logic [2:0] {
    ST_NOT_FOUND  = 3'd0,
    ST_UPDATED    = 3'd1,
    ST_TERMINATED = 3'd2,
    ST_TIMED_OUT  = 3'd3,
    ST_INSERTED   = 3'd4,
    ST_REFRESHED  = 3'd5,
    ST_FULL       = 3'd6,
    ST_UNSUPP     = 3'd7
  } status_e;

  typedef enum logic [1:0] {
    REG_ICMP_TO = 2'd0,
    REG_TCP_TO  = 2'd1,
    REG_UDP_TO  = 2'd2
  } reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_ACT,
    S_DONE
  } state_e;

  localparam logic [7:0] IpIcmp = 8'd1;
  localparam logic [7:0] IpTcp  = 8'd6;
  localparam logic [7:0] IpUdp  = 8'd17;
  localparam logic [7:0] IcmpEchoReq = 8'd8;
  localparam logic [7:0] IcmpEchoRep = 8'd0;
  localparam logic [7:0] IcmpTsReq   = 8'd13;
  localparam logic [7:0] IcmpTsRep   = 8'd14;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  protocol;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [7:0]  icmp_kind;
    logic [15:0] icmp_ident;
    logic [15:0] icmp_seq;
    logic        rst_flag;
    logic        ack_flag;
    logic        fin_flag;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [5:0] entry_index;
    logic [6:0] removed_count;
  } rsp_t;

  typedef struct packed {
    logic [1:0]  proto;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [7:0]  icmp_kind;
    logic [15:0] icmp_ident;
    logic [15:0] icmp_seq;
    logic        fwd_fin;
    logic        rev_fin;
    logic [31:0] last_seen;
  } slot_t;

  function automatic logic [1:0] proto_code(logic [7:0] p);
    logic [1:0] r;
    r = PC_NONE;
    if (p == IpIcmp) r = PC_ICMP;
    else if (p == IpTcp) r = PC_TCP;
    else if (p == IpUdp) r = PC_UDP;
    return r;
  endfunction

endpackage

// File: rtl/connection_tracking_table_core.sv
// One item in flight at a time; start is taken only while busy is low. Track, insert
// and sweep walk every slot through the single read port of the slot memory, one slot a
// cycle, and drain the read pipeline; track and insert then act on the chosen slot.
// done_o is registered from the done state, so it rises once busy is already low and
// the next start can be taken while done_o is high. Ticks, and track or insert items of
// an unsupported protocol, skip the walk and go straight to the done state. The result
// is shown on result_o for one cycle with done_o high; the receiver cannot hold it off.
// No clearing pass: slot valid bits reset at once.
module connection_tracking_table_core #(
  parameter int unsigned ENTRIES = ctt_pkg::EntriesDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  ctt_pkg::req_t req_i,
  output logic          done_o,
  output ctt_pkg::rsp_t result_o,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_idx_i,
  input  logic [15:0]   cfg_data_i
);

  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  ctt_pkg::state_e state_q, state_d;
  ctt_pkg::req_t   req_q;
  logic [1:0]      pc_q;
  logic [15:0]     icmp_to_q, tcp_to_q, udp_to_q;
  logic [31:0]     now_q;
  logic [ENTRIES-1:0] valid_q;

  ctt_pkg::slot_t  mem [ENTRIES];
  ctt_pkg::slot_t  rd_q;
  logic [IW:0]     ridx_q;
  logic            rvld_q;
  logic [IW-1:0]   ridx_d1_q;

  logic            hit_q, free_q;
  logic [IW-1:0]   hit_idx_q, free_idx_q;
  ctt_pkg::slot_t  hit_slot_q;
  logic [6:0]      removed_q;
  ctt_pkg::rsp_t   rsp_q;

  logic            accept;
  assign accept = start && !busy;
  assign busy   = (state_q != ctt_pkg::S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      icmp_to_q <= 16'd30;
      tcp_to_q  <= 16'd3600;
      udp_to_q  <= 16'd60;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ctt_pkg::REG_ICMP_TO: icmp_to_q <= cfg_data_i;
        ctt_pkg::REG_TCP_TO:  tcp_to_q  <= cfg_data_i;
        ctt_pkg::REG_UDP_TO:  udp_to_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // expiry and match of the slot just read
  logic [15:0] to_sel;
  logic        rd_exp, rd_match, ip_ok, kind_ok;
  always_comb begin
    case (rd_q.proto)
      ctt_pkg::PC_ICMP: to_sel = icmp_to_q;
      ctt_pkg::PC_TCP:  to_sel = tcp_to_q;
      default:          to_sel = udp_to_q;
    endcase
    rd_exp = (now_q - rd_q.last_seen) > {16'd0, to_sel};
    ip_ok = (req_q.src_ip == rd_q.src_ip && req_q.dst_ip == rd_q.dst_ip) ||
            (req_q.src_ip == rd_q.dst_ip && req_q.dst_ip == rd_q.src_ip);
    kind_ok = (req_q.icmp_kind == rd_q.icmp_kind) ||
              (rd_q.icmp_kind == ctt_pkg::IcmpEchoReq &&
               req_q.icmp_kind == ctt_pkg::IcmpEchoRep) ||
              (rd_q.icmp_kind == ctt_pkg::IcmpTsReq &&
               req_q.icmp_kind == ctt_pkg::IcmpTsRep);
    rd_match = valid_q[ridx_d1_q] && rd_q.proto == pc_q && ip_ok;
    if (pc_q == ctt_pkg::PC_ICMP) begin
      rd_match = rd_match && kind_ok && req_q.icmp_ident == rd_q.icmp_ident;
    end else begin
      rd_match = rd_match &&
        ((req_q.sport == rd_q.sport && req_q.dport == rd_q.dport) ||
         (req_q.sport == rd_q.dport && req_q.dport == rd_q.sport));
    end
  end

  logic scanning;
  assign scanning = (state_q == ctt_pkg::S_SCAN);
  logic last_rd;
  assign last_rd = (ridx_q == (IW+1)'(ENTRIES));

  always_ff @(posedge clk_i) begin
    if (scanning && !last_rd) rd_q <= mem[ridx_q[IW-1:0]];
  end

  // write port
  logic           we;
  logic [IW-1:0]  waddr;
  ctt_pkg::slot_t wdata;
  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ctt_pkg::S_IDLE: begin
        if (accept) begin
          if (req_i.operation == ctt_pkg::OP_TICK ||
              (req_i.operation != ctt_pkg::OP_SWEEP &&
               ctt_pkg::proto_code(req_i.protocol) == ctt_pkg::PC_NONE)) begin
            state_d = ctt_pkg::S_DONE;
          end else begin
            state_d = ctt_pkg::S_SCAN;
          end
        end
      end
      ctt_pkg::S_SCAN: if (last_rd && !rvld_q) state_d = ctt_pkg::S_ACT;
      ctt_pkg::S_ACT:  state_d = ctt_pkg::S_DONE;
      ctt_pkg::S_DONE: state_d = ctt_pkg::S_IDLE;
      default:         state_d = ctt_pkg::S_IDLE;
    endcase
  end

  // action on the chosen slot
  logic             clr_v, set_v;
  logic [IW-1:0]    v_idx;
  ctt_pkg::rsp_t    act_rsp;
  always_comb begin
    we = 1'b0; waddr = hit_idx_q; wdata = hit_slot_q;
    clr_v = 1'b0; set_v = 1'b0; v_idx = hit_idx_q;
    act_rsp = '0;
    act_rsp.status = ctt_pkg::ST_UPDATED;
    act_rsp.removed_count = removed_q;
    if (state_q == ctt_pkg::S_ACT && req_q.operation == ctt_pkg::OP_TRACK) begin
      if (!hit_q) begin
        act_rsp.status = ctt_pkg::ST_NOT_FOUND;
      end else begin
        act_rsp.entry_index = 6'(hit_idx_q);
        if ((now_q - hit_slot_q.last_seen) >
            {16'd0, (hit_slot_q.proto == ctt_pkg::PC_ICMP) ? icmp_to_q :
                    (hit_slot_q.proto == ctt_pkg::PC_TCP) ? tcp_to_q : udp_to_q}) begin
          clr_v = 1'b1; act_rsp.status = ctt_pkg::ST_TIMED_OUT;
        end else if (pc_q == ctt_pkg::PC_TCP &&
                     (req_q.rst_flag || (req_q.ack_flag && hit_slot_q.fwd_fin &&
                                         hit_slot_q.rev_fin))) begin
          clr_v = 1'b1; act_rsp.status = ctt_pkg::ST_TERMINATED;
        end else if (pc_q == ctt_pkg::PC_ICMP &&
                     hit_slot_q.icmp_kind != req_q.icmp_kind &&
                     !(req_q.icmp_seq < hit_slot_q.icmp_seq)) begin
          clr_v = 1'b1; act_rsp.status = ctt_pkg::ST_TERMINATED;
        end else begin
          we = 1'b1;
          wdata.last_seen = now_q;
          if (pc_q == ctt_pkg::PC_TCP && req_q.fin_flag) begin
            if (hit_slot_q.src_ip == req_q.src_ip) wdata.fwd_fin = 1'b1;
            else wdata.rev_fin = 1'b1;
          end
          if (pc_q == ctt_pkg::PC_ICMP && hit_slot_q.icmp_kind == req_q.icmp_kind) begin
            wdata.icmp_seq = req_q.icmp_seq;
          end
        end
      end
    end else if (state_q == ctt_pkg::S_ACT && req_q.operation == ctt_pkg::OP_INSERT) begin
      if (hit_q) begin
        we = 1'b1; wdata.last_seen = now_q;
        act_rsp.entry_index = 6'(hit_idx_q);
        act_rsp.status = ctt_pkg::ST_REFRESHED;
      end else if (!free_q) begin
        act_rsp.status = ctt_pkg::ST_FULL;
      end else begin
        we = 1'b1; waddr = free_idx_q; set_v = 1'b1; v_idx = free_idx_q;
        wdata.proto = pc_q;
        wdata.src_ip = req_q.src_ip;
        wdata.dst_ip = req_q.dst_ip;
        wdata.fwd_fin = 1'b0;
        wdata.rev_fin = 1'b0;
        wdata.last_seen = now_q;
        if (pc_q == ctt_pkg::PC_ICMP) begin
          wdata.sport = '0; wdata.dport = '0;
          wdata.icmp_kind = req_q.icmp_kind;
          wdata.icmp_ident = req_q.icmp_ident;
          wdata.icmp_seq = req_q.icmp_seq;
        end else begin
          wdata.sport = req_q.sport; wdata.dport = req_q.dport;
          wdata.icmp_kind = '0; wdata.icmp_ident = '0; wdata.icmp_seq = '0;
        end
        act_rsp.entry_index = 6'(free_idx_q);
        act_rsp.status = ctt_pkg::ST_INSERTED;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ctt_pkg::S_IDLE;
      now_q      <= '0;
      valid_q    <= '0;
      ridx_q     <= '0;
      rvld_q     <= 1'b0;
      ridx_d1_q  <= '0;
      hit_q      <= 1'b0;
      free_q     <= 1'b0;
      hit_idx_q  <= '0;
      free_idx_q <= '0;
      hit_slot_q <= '0;
      removed_q  <= '0;
      done_o     <= 1'b0;
    end else begin
      state_q <= state_d;
      done_o  <= (state_q == ctt_pkg::S_DONE);
      rvld_q  <= scanning && !last_rd;
      if (scanning && !last_rd) begin
        ridx_d1_q <= ridx_q[IW-1:0];
        ridx_q    <= ridx_q + (IW+1)'(1);
      end
      if (accept) begin
        ridx_q <= '0; hit_q <= 1'b0; free_q <= 1'b0; removed_q <= '0;
        if (req_i.operation == ctt_pkg::OP_TICK) now_q <= now_q + 32'd1;
      end
      if (rvld_q) begin
        if (req_q.operation == ctt_pkg::OP_SWEEP) begin
          if (valid_q[ridx_d1_q] && rd_exp) begin
            valid_q[ridx_d1_q] <= 1'b0;
            if (removed_q != 7'd127) removed_q <= removed_q + 7'd1;
          end
        end else begin
          if (rd_match && !hit_q) begin
            hit_q <= 1'b1; hit_idx_q <= ridx_d1_q; hit_slot_q <= rd_q;
          end
          if (!valid_q[ridx_d1_q] && !free_q) begin
            free_q <= 1'b1; free_idx_q <= ridx_d1_q;
          end
        end
      end
      if (clr_v) valid_q[v_idx] <= 1'b0;
      if (set_v) valid_q[v_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
      pc_q  <= ctt_pkg::proto_code(req_i.protocol);
      rsp_q <= '{status: (req_i.operation == ctt_pkg::OP_TICK) ? ctt_pkg::ST_UPDATED
                                                               : ctt_pkg::ST_UNSUPP,
                 default: '0};
    end
    if (state_q == ctt_pkg::S_ACT) rsp_q <= act_rsp;
    if (state_q == ctt_pkg::S_DONE) result_o <= rsp_q;
  end

endmodule
